// ----- design/fpr_pkg.sv -----
// fpr_pkg: shared types and constants for the fifo page replacement unit
// no dependencies; imported by every module of the block
package fpr_pkg;

   localparam int unsigned MAX_FRAMES_DEF = 16;
   localparam int unsigned PAGE_BITS_DEF  = 16;

   // configuration port
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned FRAMES_W    = 5;
   localparam logic [FRAMES_W-1:0] FRAMES_RESET = 5'd16;

   // register index taken from paddr[2]
   localparam logic REG_FRAMES_IN_USE = 1'b0;

   localparam logic [31:0] FAULT_MAX = 32'hFFFF_FFFF;

   // controls broadcast to every cell of the row
   typedef struct packed {
      logic shift;   // fault: each cell takes its younger neighbor's page
      logic clear;   // empty the store
   } cell_ctrl_type;

   // status returned by one cell
   typedef struct packed {
      logic valid;
      logic match;
      logic tail_full;   // this cell is the last enabled one and holds a page
   } cell_stat_type;

endpackage

// ----- design/fpr_cell.sv -----
// fpr_cell: one frame of the resident page row, holds a page and its valid bit
// depends on fpr_pkg; a row of these is built in fifo_page_replacement_unit
module fpr_cell
   import fpr_pkg::*;
#(
   parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   input  logic                 enabled,
   input  logic                 last,
   input  logic [PAGE_BITS-1:0] page,
   input  logic                 prev_valid,
   input  logic [PAGE_BITS-1:0] prev_data,
   output cell_stat_type        stat,
   output logic [PAGE_BITS-1:0] data,
   output logic [PAGE_BITS-1:0] tail_data
);

   logic                 valid_ff;
   logic                 valid_in;
   logic [PAGE_BITS-1:0] data_ff;
   logic [PAGE_BITS-1:0] data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         // cells past the configured capacity never hold a page
         valid_in = prev_valid & enabled;
         data_in  = prev_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign stat.valid     = valid_ff;
   assign stat.match     = valid_ff & (data_ff == page);
   assign stat.tail_full = valid_ff & last;
   assign data           = data_ff;
   assign tail_data      = last ? data_ff : '0;

endmodule

// ----- design/fpr_csr.sv -----
// fpr_csr: apb register holding frames_in_use, derives the effective capacity
// depends on fpr_pkg; instantiated by fifo_page_replacement_unit
module fpr_csr
   import fpr_pkg::*;
#(
   parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF,
   localparam int unsigned CAP_W     = $clog2(MAX_FRAMES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [CAP_W-1:0]      capacity,
   output logic                  store_clear
);

   logic [FRAMES_W-1:0] frames_ff;
   logic [FRAMES_W-1:0] frames_in;
   logic                wr_en;
   logic                frames_wr;
   logic [6:0]          frames_ext;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      frames_wr = 1'b0;
      unique case (csr_paddr[2])
         REG_FRAMES_IN_USE: frames_wr = wr_en;
         default:           frames_wr = 1'b0;
      endcase
   end

   assign frames_in   = frames_wr ? csr_pwdata[FRAMES_W-1:0] : frames_ff;
   assign store_clear = frames_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FRAMES_RESET;
      end else begin
         frames_ff <= frames_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         REG_FRAMES_IN_USE: csr_prdata = CSR_DATA_W'(frames_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // zero acts as one frame, anything above the row length as the row length
   assign frames_ext = 7'(frames_ff);
   always_comb begin
      if (frames_ff == '0) begin
         capacity = CAP_W'(1);
      end else if (frames_ext > 7'(MAX_FRAMES)) begin
         capacity = CAP_W'(MAX_FRAMES);
      end else begin
         capacity = CAP_W'(frames_ff);
      end
   end

endmodule

// ----- design/fifo_page_replacement_unit.sv -----
// fifo_page_replacement_unit: fifo page replacement over a shifting row of cells
// depends on fpr_pkg, fpr_cell and fpr_csr
// the result strobe comes in the cycle after start; throughput one item per cycle
// (all cells compare in parallel and the row shifts in the same cycle), busy stays low
// reset: store empty, frames_in_use 16, fault counter 0; results cannot be stalled
module fifo_page_replacement_unit
   import fpr_pkg::*;
#(
   parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF,
   parameter int unsigned PAGE_BITS  = PAGE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [PAGE_BITS-1:0]  req_page_number,
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   output logic                  rsp_evict_valid,
   output logic [PAGE_BITS-1:0]  rsp_evicted_page,
   output logic [31:0]           rsp_fault_total,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int unsigned CAP_W = $clog2(MAX_FRAMES + 1);

   logic [CAP_W-1:0]     capacity;
   logic                 store_clear;
   logic                 accept;
   logic                 hit;
   logic                 fault;
   logic                 evict;
   logic [PAGE_BITS-1:0] evicted;
   cell_ctrl_type        ctrl;

   cell_stat_type        stat      [MAX_FRAMES];
   logic [PAGE_BITS-1:0] data      [MAX_FRAMES];
   logic [PAGE_BITS-1:0] tail_data [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] valid_vec;
   logic [MAX_FRAMES-1:0] match_vec;
   logic [MAX_FRAMES-1:0] tail_vec;

   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic                 rsp_evict_valid_ff;
   logic [PAGE_BITS-1:0] rsp_evicted_page_ff;
   logic [31:0]          fault_ff;
   logic [31:0]          fault_in;

   fpr_csr #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .capacity    (capacity),
      .store_clear (store_clear)
   );

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign ctrl.shift = fault;
   assign ctrl.clear = store_clear;

   // youngest page enters at cell 0, the oldest sits in the last enabled cell
   for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
      logic                 prev_valid;
      logic [PAGE_BITS-1:0] prev_data;

      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
         assign prev_data  = req_page_number;
      end else begin : g_link
         assign prev_valid = stat[i-1].valid;
         assign prev_data  = data[i-1];
      end

      fpr_cell #(
         .PAGE_BITS (PAGE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .enabled    (CAP_W'(i) < capacity),
         .last       (CAP_W'(i + 1) == capacity),
         .page       (req_page_number),
         .prev_valid (prev_valid),
         .prev_data  (prev_data),
         .stat       (stat[i]),
         .data       (data[i]),
         .tail_data  (tail_data[i])
      );

      assign valid_vec[i] = stat[i].valid;
      assign match_vec[i] = stat[i].match;
      assign tail_vec[i]  = stat[i].tail_full;
   end

   assign hit   = |match_vec;
   assign fault = accept & ~hit;
   assign evict = fault & (|tail_vec);

   always_comb begin
      evicted = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         evicted = evicted | tail_data[i];
      end
      if (!evict) begin
         evicted = '0;
      end
   end

   assign fault_in = (fault && fault_ff != FAULT_MAX) ? fault_ff + 32'd1 : fault_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         fault_ff     <= '0;
      end else begin
         rsp_valid_ff <= accept;
         fault_ff     <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_hit_ff          <= hit;
         rsp_evict_valid_ff  <= evict;
         rsp_evicted_page_ff <= evicted;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_evict_valid  = rsp_evict_valid_ff;
   assign rsp_evicted_page = rsp_evicted_page_ff;
   assign rsp_fault_total  = fault_ff;

   // resident pages always form an unbroken run from cell 0
   a_valid_contiguous: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + MAX_FRAMES'(1)) & valid_vec) == '0)
      else $error("resident pages not contiguous");

   a_count_in_capacity: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) <= 32'(capacity))
      else $error("more resident pages than frames");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted item gave no result");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_evict_valid && rsp_evicted_page == '0)
      else $error("hit reported an eviction");

   a_fault_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> fault_ff >= $past(fault_ff))
      else $error("fault counter went backwards");

   a_evict_when_full: assert property (@(posedge clock) disable iff (reset)
      evict |-> $countones(valid_vec) == 32'(capacity))
      else $error("eviction from a store that is not full");

endmodule
